// File: src/isl_pkg.sv
// Package for the indexed shift list: capacity, derived widths, request and
// result structs, mode and status codes, and the broadcast cell command.
// No dependencies.
`timescale 1ns / 1ps

package isl_pkg;

    localparam int CAPACITY = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int POS_W    = 6;
    localparam int LEN_W    = 6;
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [2:0] {
        MODE_APPEND = 3'd0,
        MODE_INSERT = 3'd1,
        MODE_ERASE  = 3'd2,
        MODE_READ   = 3'd3,
        MODE_WRITE  = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_FULL   = 2'd1,
        ST_BADPOS = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_APPEND = 3'd1,
        OP_INSERT = 3'd2,
        OP_ERASE  = 3'd3,
        OP_WRITE  = 3'd4
    } t_op;

    typedef struct packed {
        logic [2:0]         mode;
        logic [POS_W-1:0]   position;
        logic signed [31:0] value;
    } t_req;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [LEN_W-1:0]   list_length;
        logic               is_empty;
        logic [1:0]         status;
    } t_rsp;

    // Command broadcast to every cell in the row.
    typedef struct packed {
        t_op                op;
        logic [CMP_W-1:0]   pos;
        logic [CMP_W-1:0]   cnt;
        logic signed [31:0] word;
    } t_cell_cmd;

endpackage

// File: src/isl_cell.sv
// One list entry of the indexed shift list: holds a word and takes a new
// value, its lower neighbor's or its upper neighbor's. Depends on isl_pkg.
`timescale 1ns / 1ps

module isl_cell
    import isl_pkg::*;
(
    input  logic               i_clk,
    input  logic [IDX_W-1:0]   i_index,
    input  t_cell_cmd          i_cmd,
    input  logic signed [31:0] i_lower,
    input  logic signed [31:0] i_upper,
    output logic signed [31:0] o_data
);

    logic signed [31:0] r_data;
    logic signed [31:0] n_data;
    logic [CMP_W-1:0]   kx;
    logic [CMP_W-1:0]   kx_next;

    assign kx      = CMP_W'(i_index);
    assign kx_next = CMP_W'(kx + CMP_W'(1));

    always_comb begin
        n_data = r_data;
        case (i_cmd.op)
            OP_APPEND: begin
                if (kx == i_cmd.cnt) n_data = i_cmd.word;
            end
            OP_INSERT: begin
                if (kx == i_cmd.pos) begin
                    n_data = i_cmd.word;
                end else if (kx > i_cmd.pos && kx <= i_cmd.cnt) begin
                    n_data = i_lower;
                end
            end
            OP_ERASE: begin
                if (kx >= i_cmd.pos && kx_next < i_cmd.cnt) n_data = i_upper;
            end
            OP_WRITE: begin
                if (kx == i_cmd.pos) n_data = i_cmd.word;
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// File: src/indexed_shift_list_core.sv
// Indexed shift list: fixed-capacity ordered list of signed words in a row
// of cells. Depends on isl_pkg and isl_cell.
`timescale 1ns / 1ps
// The result strobes in the cycle after the item is accepted.
// Throughput: one item per cycle; busy stays low, since every cell shifts
// with its neighbor in the same cycle and the count updates alongside.
// Reset (synchronous, active low) clears the count and the result strobe;
// entry contents are not cleared and are never read before being written.
// The receiver cannot stall: each result is shown for exactly one cycle.

module indexed_shift_list_core
    import isl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_req i_req,
    output logic busy,
    output logic o_strobe,
    output t_rsp o_rsp
);

    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               r_strobe;
    t_rsp               r_rsp;
    t_rsp               n_rsp;
    t_cell_cmd          cmd;
    logic               accept;
    logic               full;
    logic [CMP_W-1:0]   pos_x;
    logic [CMP_W-1:0]   cnt_x;
    logic [IDX_W-1:0]   rd_idx;
    logic signed [31:0] cell_q [CAPACITY];

    // Never stall: every item finishes in the cycle it is accepted.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign pos_x  = CMP_W'(i_req.position);
    assign cnt_x  = CMP_W'(r_count);
    assign full   = (r_count == CNT_W'(CAPACITY));
    assign rd_idx = IDX_W'(pos_x);

    // Decode the request: check bounds, pick the cell operation, and build
    // the result from the count after this item.
    always_comb begin
        t_status st;
        t_op     op;
        logic signed [31:0] rd;
        st      = ST_DONE;
        op      = OP_NONE;
        rd      = '0;
        n_count = r_count;
        case (i_req.mode)
            MODE_APPEND: begin
                if (full) begin
                    st = ST_FULL;
                end else begin
                    op      = OP_APPEND;
                    n_count = CNT_W'(r_count + CNT_W'(1));
                end
            end
            MODE_INSERT: begin
                // Position check comes ahead of the full check.
                if (pos_x > cnt_x) begin
                    st = ST_BADPOS;
                end else if (full) begin
                    st = ST_FULL;
                end else begin
                    op      = OP_INSERT;
                    n_count = CNT_W'(r_count + CNT_W'(1));
                end
            end
            MODE_ERASE: begin
                if (pos_x >= cnt_x) begin
                    st = ST_BADPOS;
                end else begin
                    op      = OP_ERASE;
                    n_count = CNT_W'(r_count - CNT_W'(1));
                end
            end
            MODE_READ: begin
                if (pos_x >= cnt_x) st = ST_BADPOS;
                else rd = cell_q[rd_idx];
            end
            MODE_WRITE: begin
                if (pos_x >= cnt_x) st = ST_BADPOS;
                else op = OP_WRITE;
            end
            default: begin
                // Unknown modes leave everything as it is.
                st = ST_DONE;
            end
        endcase

        if (!accept) begin
            op      = OP_NONE;
            n_count = r_count;
        end

        cmd.op   = op;
        cmd.pos  = pos_x;
        cmd.cnt  = cnt_x;
        cmd.word = i_req.value;

        n_rsp.read_value  = rd;
        n_rsp.list_length = LEN_W'(n_count);
        n_rsp.is_empty    = (n_count == '0);
        n_rsp.status      = st;
    end

    // Row of cells; each sees its neighbors' words for shifting.
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic signed [31:0] lower;
        logic signed [31:0] upper;
        if (k == 0) begin : g_first
            assign lower = '0;
        end else begin : g_lo
            assign lower = cell_q[k-1];
        end
        if (k == CAPACITY - 1) begin : g_last
            assign upper = '0;
        end else begin : g_hi
            assign upper = cell_q[k+1];
        end
        isl_cell u_cell (
            .i_clk   (i_clk),
            .i_index (IDX_W'(k)),
            .i_cmd   (cmd),
            .i_lower (lower),
            .i_upper (upper),
            .o_data  (cell_q[k])
        );
    end

    // Hold the count; drop the strobe in reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_strobe <= accept;
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (accept) r_rsp <= n_rsp;
    end

    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

`ifndef SYNTH
    a_strobe_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_strobe)
        else $error("accepted item produced no result strobe");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_full_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_rsp.status == ST_FULL) |-> o_rsp.list_length == LEN_W'(CAPACITY))
        else $error("full status reported while list not at capacity");

    a_rd_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_rsp.status != ST_DONE) |-> o_rsp.read_value == '0)
        else $error("nonzero read value on a failed request");
`endif

endmodule

// File: verif/tb_indexed_shift_list_core.sv
// Self-checking testbench for indexed_shift_list_core: directed and random append,
// insert, erase, read, write and undecoded-mode requests checked against an in-bench list model.
// Depends on isl_pkg and the indexed_shift_list_core RTL.
`timescale 1ns / 1ps

module tb_indexed_shift_list_core
    import isl_pkg::*;
();

    // Modes 5..7 are not decoded by the block; it must answer them as no-ops.
    localparam logic [2:0] MODE_RSVD_0 = 3'd5;
    localparam logic [2:0] MODE_RSVD_1 = 3'd6;
    localparam logic [2:0] MODE_RSVD_2 = 3'd7;
    localparam int         POS_MAX     = (1 << POS_W) - 1;
    localparam int         N_RANDOM    = 850;

    // One queued request: the payload, idle cycles to hold after it is taken,
    // and whether to wait for every outstanding result before offering it.
    typedef struct {
        t_req        req;
        int unsigned gap;
        bit          drain;
    } t_list_cmd;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_req i_req   = '0;
    logic busy;
    logic o_strobe;
    t_rsp o_rsp;

    t_list_cmd cmd_queue[$];
    t_rsp      due_results[$];

    // Model of the list contents and length.
    logic signed [31:0] list_words [CAPACITY];
    int                 list_len  = 0;
    int                 peak_len  = 0;

    // Length seen by the stimulus generator, used to aim positions.
    int gen_len = 0;

    t_list_cmd   drv_cmd;
    t_rsp        drv_rsp;
    t_rsp        mon_exp;
    int unsigned idle_left  = 0;
    int unsigned cur_gap    = 0;
    int unsigned n_accepted = 0;
    int unsigned n_results  = 0;
    int unsigned n_full     = 0;
    int unsigned n_badpos   = 0;
    int unsigned n_errors   = 0;

    indexed_shift_list_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_req    (i_req),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_rsp    (o_rsp)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("indexed_shift_list_core verification failed");
        $finish;
    end

    task automatic note_mismatch(input string msg);
        n_errors++;
        $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    // Apply one request to the list model and build the result it must give.
    // Bounds come first; on insert the position check wins over the full check.
    task automatic apply_list_op(input t_req r, output t_rsp rsp);
        int                 k;
        logic signed [31:0] rd;
        t_status            st;
        rd = '0;
        st = ST_DONE;
        case (r.mode)
            MODE_APPEND: begin
                if (list_len >= CAPACITY) begin
                    st = ST_FULL;
                end else begin
                    list_words[list_len] = r.value;
                    list_len++;
                end
            end
            MODE_INSERT: begin
                if (r.position > list_len) begin
                    st = ST_BADPOS;
                end else if (list_len >= CAPACITY) begin
                    st = ST_FULL;
                end else begin
                    for (k = list_len; k > r.position; k--)
                        list_words[k] = list_words[k-1];
                    list_words[r.position] = r.value;
                    list_len++;
                end
            end
            MODE_ERASE: begin
                if (r.position >= list_len) begin
                    st = ST_BADPOS;
                end else begin
                    for (k = r.position; k + 1 < list_len; k++)
                        list_words[k] = list_words[k+1];
                    list_len--;
                end
            end
            MODE_READ: begin
                if (r.position >= list_len)
                    st = ST_BADPOS;
                else
                    rd = list_words[r.position];
            end
            MODE_WRITE: begin
                if (r.position >= list_len)
                    st = ST_BADPOS;
                else
                    list_words[r.position] = r.value;
            end
            default: ;
        endcase
        if (list_len > peak_len)
            peak_len = list_len;
        rsp.read_value  = rd;
        rsp.list_length = list_len[LEN_W-1:0];
        rsp.is_empty    = (list_len == 0);
        rsp.status      = st;
    endtask

    // Queue one request and track the length it leaves behind, so later
    // positions can be aimed at the live part of the list and its edges.
    task automatic add_item(input logic [2:0] mode, input int pos, input logic [31:0] value,
                            input int gap, input bit drain);
        t_list_cmd c;
        c.req.mode     = mode;
        c.req.position = pos[POS_W-1:0];
        c.req.value    = value;
        c.gap          = gap;
        c.drain        = drain;
        cmd_queue.push_back(c);
        case (mode)
            MODE_APPEND: if (gen_len < CAPACITY) gen_len++;
            MODE_INSERT: if (pos <= gen_len && gen_len < CAPACITY) gen_len++;
            MODE_ERASE:  if (pos < gen_len) gen_len--;
            default: ;
        endcase
    endtask

    // Driver: take the item on the bus when start meets a low busy, predict
    // its result, then hold the bus idle for the item's gap before offering
    // the next one. A drain item is held back until nothing is outstanding.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            idle_left = 0;
        end else begin
            if (start && !busy) begin
                apply_list_op(i_req, drv_rsp);
                due_results.push_back(drv_rsp);
                if (drv_rsp.status == ST_FULL)
                    n_full++;
                if (drv_rsp.status == ST_BADPOS)
                    n_badpos++;
                idle_left = cur_gap;
                n_accepted++;
            end
            // Only touch the bus when the slot is free; otherwise hold it.
            if (!start || !busy) begin
                if (idle_left != 0) begin
                    idle_left--;
                    start <= 1'b0;
                end else if (cmd_queue.size() != 0 &&
                             !(cmd_queue[0].drain && due_results.size() != 0)) begin
                    drv_cmd = cmd_queue.pop_front();
                    i_req   <= drv_cmd.req;
                    cur_gap = drv_cmd.gap;
                    start   <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: every strobe retires the oldest prediction, field by field.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (due_results.size() == 0) begin
                note_mismatch($sformatf("result %0d with nothing outstanding", n_results));
            end else begin
                mon_exp = due_results.pop_front();
                if (o_rsp.read_value !== mon_exp.read_value)
                    note_mismatch($sformatf("result %0d read_value %h, want %h", n_results,
                                            o_rsp.read_value, mon_exp.read_value));
                if (o_rsp.list_length !== mon_exp.list_length)
                    note_mismatch($sformatf("result %0d list_length %0d, want %0d", n_results,
                                            o_rsp.list_length, mon_exp.list_length));
                if (o_rsp.is_empty !== mon_exp.is_empty)
                    note_mismatch($sformatf("result %0d is_empty %b, want %b", n_results,
                                            o_rsp.is_empty, mon_exp.is_empty));
                if (o_rsp.status !== mon_exp.status)
                    note_mismatch($sformatf("result %0d status %0d, want %0d", n_results,
                                            o_rsp.status, mon_exp.status));
            end
            n_results++;
        end
    end

    initial begin
        int          n_rand;
        int          r;
        int          p;
        int          g;
        int          full_hits;
        int          empty_hits;
        int          burst_left;
        bit          growing;
        logic [2:0]  m;
        logic [31:0] v;

        n_rand     = 0;
        full_hits  = 0;
        empty_hits = 0;
        burst_left = 0;
        growing    = 1'b1;

        // Directed opening: empty-list bounds, both value extremes, insert at
        // front, middle and end, insert one past the end, reads at the edges,
        // erase front and back, the undecoded modes, and the top position.
        add_item(MODE_READ,   0, 32'h0000_0000, 0, 1'b0);
        add_item(MODE_ERASE,  0, 32'h0000_0000, 0, 1'b0);
        add_item(MODE_WRITE,  0, 32'hFFFF_FFFF, 1, 1'b0);
        add_item(MODE_INSERT, 1, 32'h1111_1111, 0, 1'b0);
        add_item(MODE_INSERT, 0, 32'h7FFF_FFFF, 0, 1'b0);
        add_item(MODE_APPEND, 0, 32'h8000_0000, 0, 1'b0);
        add_item(MODE_APPEND, 0, 32'h0000_0000, 2, 1'b0);
        add_item(MODE_APPEND, 0, 32'hFFFF_FFFF, 0, 1'b0);
        add_item(MODE_INSERT, 2, 32'h5555_5555, 0, 1'b0);
        add_item(MODE_INSERT, 5, 32'hAAAA_AAAA, 0, 1'b0);
        add_item(MODE_INSERT, 7, 32'h2222_2222, 0, 1'b0);
        add_item(MODE_READ,   0, 32'h0000_0000, 0, 1'b0);
        add_item(MODE_READ,   5, 32'h0000_0000, 0, 1'b0);
        add_item(MODE_READ,   6, 32'h0000_0000, 1, 1'b0);
        add_item(MODE_WRITE,  3, 32'h1234_5678, 0, 1'b0);
        add_item(MODE_READ,   3, 32'h0000_0000, 0, 1'b0);
        add_item(MODE_ERASE,  0, 32'h0000_0000, 0, 1'b0);
        add_item(MODE_ERASE,  4, 32'h0000_0000, 0, 1'b0);
        add_item(MODE_RSVD_0, 1, 32'hDEAD_BEEF, 0, 1'b0);
        add_item(MODE_RSVD_1, 2, 32'h0BAD_F00D, 0, 1'b0);
        add_item(MODE_RSVD_2, POS_MAX, 32'hFFFF_FFFF, 0, 1'b0);
        add_item(MODE_READ,   POS_MAX, 32'h0000_0000, 0, 1'b0);
        add_item(MODE_ERASE,  POS_MAX, 32'h0000_0000, 3, 1'b0);
        // Pressure point: hold this read until the pipe has fully drained.
        add_item(MODE_READ,   2, 32'h0000_0000, 0, 1'b1);

        // Random part: swing between a growing phase that fills the list and
        // dwells at full, and a shrinking phase that empties it, so both
        // ends and every shift distance are exercised many times.
        while (n_rand < N_RANDOM) begin
            if (gen_len == CAPACITY)
                full_hits++;
            if (gen_len == 0)
                empty_hits++;
            if (growing && full_hits > 6) begin
                growing   = 1'b0;
                full_hits = 0;
            end
            if (!growing && empty_hits > 4) begin
                growing    = 1'b1;
                empty_hits = 0;
            end

            r = $urandom_range(0, 99);
            if (r < 3) begin
                case ($urandom_range(0, 2))
                    0:       m = MODE_RSVD_0;
                    1:       m = MODE_RSVD_1;
                    default: m = MODE_RSVD_2;
                endcase
            end else if (growing) begin
                m = (r < 38) ? MODE_APPEND : (r < 65) ? MODE_INSERT :
                    (r < 75) ? MODE_ERASE  : (r < 88) ? MODE_READ : MODE_WRITE;
            end else begin
                m = (r < 10) ? MODE_APPEND : (r < 20) ? MODE_INSERT :
                    (r < 62) ? MODE_ERASE  : (r < 82) ? MODE_READ : MODE_WRITE;
            end

            // Aim mostly inside the list, often at its edges, sometimes anywhere.
            r = $urandom_range(0, 99);
            if (r < 60) begin
                if (m == MODE_INSERT)
                    p = $urandom_range(0, gen_len);
                else
                    p = (gen_len == 0) ? 0 : $urandom_range(0, gen_len - 1);
            end else if (r < 70) begin
                p = 0;
            end else if (r < 80) begin
                p = gen_len;
            end else if (r < 88) begin
                p = gen_len + 1;
            end else begin
                p = $urandom_range(0, POS_MAX);
            end

            r = $urandom_range(0, 99);
            case (r % 4)
                0:       v = 32'h7FFF_FFFF;
                1:       v = 32'h8000_0000;
                2:       v = 32'hFFFF_FFFF;
                default: v = 32'h0000_0000;
            endcase
            if (r >= 12)
                v = $urandom;

            // Idle gaps: mostly none or short, a few long, with bursts of
            // back-to-back items in between.
            if (burst_left > 0) begin
                g = 0;
                burst_left--;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 4) begin
                    burst_left = $urandom_range(20, 60);
                    g = 0;
                end else if (r < 55) begin
                    g = 0;
                end else if (r < 85) begin
                    g = $urandom_range(1, 3);
                end else if (r < 97) begin
                    g = $urandom_range(4, 10);
                end else begin
                    g = $urandom_range(11, 40);
                end
            end

            add_item(m, p, v, g, (n_rand % 120) == 119);
            if (m <= MODE_WRITE)
                n_rand++;
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for the driver to run dry and every result to come home, then
        // keep the clock running so that any stray strobe would show.
        while (cmd_queue.size() != 0 || start || due_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("Run covered %0d requests and %0d results, peak length %0d of %0d.",
                 n_accepted, n_results, peak_len, CAPACITY);
        $display("Full-list rejects: %0d, out-of-range rejects: %0d, mismatches: %0d.",
                 n_full, n_badpos, n_errors);
        if (n_errors == 0)
            $display("indexed_shift_list_core verification clean");
        else
            $display("indexed_shift_list_core verification failed");
        $finish;
    end

endmodule

// File: indexed_shift_list_core.f
src/isl_pkg.sv
src/isl_cell.sv
src/indexed_shift_list_core.sv
verif/tb_indexed_shift_list_core.sv
